[sv/dsd_pkg.sv]
`default_nettype none

package dsd_pkg;

   localparam int YEAR_W = 14;
   localparam int MON_W  = 5 - 1;
   localparam int DAY_W  = 5;
   localparam int SPAN_W = 22;
   // Day number of the last day of year 16383 still fits in 23 bits.
   localparam int DN_W   = 23;
   // Year divided by four, and by sixteen.
   localparam int Q4_W   = YEAR_W - 2;
   localparam int Q16_W  = YEAR_W - 4;
   localparam int RCP_W  = 11;
   localparam int PROD_W = Q4_W + RCP_W;
   localparam int QT_W   = 8;
   localparam int OFF_W  = 9;

   localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

   // x / 25 == (x * 1311) >> 15, exact for x below 4681.
   localparam logic [RCP_W-1:0] RECIP25     = RCP_W'(1311);
   localparam int               RECIP_SHIFT = 15;
   localparam logic [Q4_W-1:0]  TWENTY_FIVE = Q4_W'(25);

   localparam logic [DN_W-1:0]  DAYS_PER_YEAR = DN_W'(365);

   localparam logic [MON_W-1:0] JANUARY  = MON_W'(1);
   localparam logic [MON_W-1:0] FEBRUARY = MON_W'(2);
   localparam logic [MON_W-1:0] DECEMBER = MON_W'(12);

   typedef struct packed {
      logic [YEAR_W-1:0] y;
      logic [YEAR_W-1:0] p;
      logic [MON_W-1:0]  m;
      logic [DAY_W-1:0]  d;
      logic              yr_ok;
      logic              mo_ok;
      logic [PROD_W-1:0] y4_prod;
      logic [PROD_W-1:0] y16_prod;
      logic [PROD_W-1:0] p4_prod;
      logic [PROD_W-1:0] p16_prod;
   } s1_type;

   typedef struct packed {
      logic [DN_W-1:0]  base;
      logic [OFF_W-1:0] off;
      logic             ok;
   } s2_type;

   // Days before the first of a month in a common year.
   function automatic logic [OFF_W-1:0] month_start(input logic [MON_W-1:0] m);
      logic [OFF_W-1:0] r;
      case (m)
         4'd1:    r = OFF_W'(0);
         4'd2:    r = OFF_W'(31);
         4'd3:    r = OFF_W'(59);
         4'd4:    r = OFF_W'(90);
         4'd5:    r = OFF_W'(120);
         4'd6:    r = OFF_W'(151);
         4'd7:    r = OFF_W'(181);
         4'd8:    r = OFF_W'(212);
         4'd9:    r = OFF_W'(243);
         4'd10:   r = OFF_W'(273);
         4'd11:   r = OFF_W'(304);
         4'd12:   r = OFF_W'(334);
         default: r = OFF_W'(0);
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:    r = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4:    r = DAY_W'(30);
         4'd6:    r = DAY_W'(30);
         4'd9:    r = DAY_W'(30);
         4'd11:   r = DAY_W'(30);
         default: r = DAY_W'(31);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/date_span_in_days_core.sv]
// Five register stages lie between req accept and rsp_valid.
// Throughput: one word per cycle; a stalled rsp channel holds the unbroken run of
// full stages at the output end, and stages behind it still move into empty ones.
// Reset clears the stage valid bits only; no state is kept between words.
`default_nettype none

module date_span_in_days_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [dsd_pkg::DAY_W-1:0]  req_first_day,
   input  wire logic [dsd_pkg::MON_W-1:0]  req_first_month,
   input  wire logic [dsd_pkg::YEAR_W-1:0] req_first_year,
   input  wire logic [dsd_pkg::DAY_W-1:0]  req_second_day,
   input  wire logic [dsd_pkg::MON_W-1:0]  req_second_month,
   input  wire logic [dsd_pkg::YEAR_W-1:0] req_second_year,
   input  wire logic [dsd_pkg::DAY_W-1:0]  req_third_day,
   input  wire logic [dsd_pkg::MON_W-1:0]  req_third_month,
   input  wire logic [dsd_pkg::YEAR_W-1:0] req_third_year,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_all_valid,
   output logic [dsd_pkg::SPAN_W-1:0]      rsp_span_days
);

   localparam int NDATE = 3;

   // Stage valid bits and advance enables. A stage loads when it is empty
   // or when the stage after it moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5      = !v5_ff || rsp_ready;
   assign adv4      = !v4_ff || adv5;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: range checks on year and month, and the reciprocal products
   // that stand in for the divisions by 100 and 400.
   // ---------------------------------------------------------------------
   logic [dsd_pkg::DAY_W-1:0]  d_in [NDATE];
   logic [dsd_pkg::MON_W-1:0]  m_in [NDATE];
   logic [dsd_pkg::YEAR_W-1:0] y_in [NDATE];

   assign d_in[0] = req_first_day;
   assign m_in[0] = req_first_month;
   assign y_in[0] = req_first_year;
   assign d_in[1] = req_second_day;
   assign m_in[1] = req_second_month;
   assign y_in[1] = req_second_year;
   assign d_in[2] = req_third_day;
   assign m_in[2] = req_third_month;
   assign y_in[2] = req_third_year;

   dsd_pkg::s1_type s1_in [NDATE];
   dsd_pkg::s1_type s1_ff [NDATE];

   always_comb begin
      for (int i = 0; i < NDATE; i++) begin
         s1_in[i].y     = y_in[i];
         s1_in[i].p     = y_in[i] - dsd_pkg::YEAR_W'(1);
         s1_in[i].m     = m_in[i];
         s1_in[i].d     = d_in[i];
         s1_in[i].yr_ok = (y_in[i] != '0) && (y_in[i] <= dsd_pkg::MAX_YEAR);
         s1_in[i].mo_ok = (m_in[i] >= dsd_pkg::JANUARY) && (m_in[i] <= dsd_pkg::DECEMBER);
         s1_in[i].y4_prod  = dsd_pkg::PROD_W'(y_in[i][dsd_pkg::YEAR_W-1:2])
                           * dsd_pkg::PROD_W'(dsd_pkg::RECIP25);
         s1_in[i].y16_prod = dsd_pkg::PROD_W'(y_in[i][dsd_pkg::YEAR_W-1:4])
                           * dsd_pkg::PROD_W'(dsd_pkg::RECIP25);
         s1_in[i].p4_prod  = dsd_pkg::PROD_W'(s1_in[i].p[dsd_pkg::YEAR_W-1:2])
                           * dsd_pkg::PROD_W'(dsd_pkg::RECIP25);
         s1_in[i].p16_prod = dsd_pkg::PROD_W'(s1_in[i].p[dsd_pkg::YEAR_W-1:4])
                           * dsd_pkg::PROD_W'(dsd_pkg::RECIP25);
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2: leap flag from the quotients by 25, day check, the
   // whole-year part of the day number and the within-year offset.
   // ---------------------------------------------------------------------
   dsd_pkg::s2_type s2_in [NDATE];
   dsd_pkg::s2_type s2_ff [NDATE];

   always_comb begin
      logic [dsd_pkg::QT_W-1:0]  qy100, qy400, qp100, qp400;
      logic [dsd_pkg::Q4_W-1:0]  y4, y16;
      logic                      by100, by400, leap;
      logic [dsd_pkg::DAY_W-1:0] mlen;
      qy100 = '0; qy400 = '0; qp100 = '0; qp400 = '0;
      y4 = '0; y16 = '0; by100 = 1'b0; by400 = 1'b0; leap = 1'b0; mlen = '0;
      for (int i = 0; i < NDATE; i++) begin
         qy100 = s1_ff[i].y4_prod [dsd_pkg::RECIP_SHIFT +: dsd_pkg::QT_W];
         qy400 = s1_ff[i].y16_prod[dsd_pkg::RECIP_SHIFT +: dsd_pkg::QT_W];
         qp100 = s1_ff[i].p4_prod [dsd_pkg::RECIP_SHIFT +: dsd_pkg::QT_W];
         qp400 = s1_ff[i].p16_prod[dsd_pkg::RECIP_SHIFT +: dsd_pkg::QT_W];
         y4    = s1_ff[i].y[dsd_pkg::YEAR_W-1:2];
         y16   = dsd_pkg::Q4_W'(s1_ff[i].y[dsd_pkg::YEAR_W-1:4]);
         // y % 100 == 0 when y % 4 == 0 and (y / 4) % 25 == 0; 400 likewise.
         by100 = (y4  - dsd_pkg::Q4_W'(dsd_pkg::Q4_W'(qy100) * dsd_pkg::TWENTY_FIVE)) == '0;
         by400 = (y16 - dsd_pkg::Q4_W'(dsd_pkg::Q4_W'(qy400) * dsd_pkg::TWENTY_FIVE)) == '0
               && (s1_ff[i].y[3:2] == 2'b00);
         leap  = (s1_ff[i].y[1:0] == 2'b00) && (!by100 || by400);
         mlen  = dsd_pkg::month_len(s1_ff[i].m, leap);

         s2_in[i].ok   = s1_ff[i].yr_ok && s1_ff[i].mo_ok
                       && (s1_ff[i].d != '0) && (s1_ff[i].d <= mlen);
         s2_in[i].base = dsd_pkg::DN_W'(s1_ff[i].p) * dsd_pkg::DAYS_PER_YEAR
                       + dsd_pkg::DN_W'(s1_ff[i].p[dsd_pkg::YEAR_W-1:2])
                       - dsd_pkg::DN_W'(qp100)
                       + dsd_pkg::DN_W'(qp400);
         s2_in[i].off  = dsd_pkg::month_start(s1_ff[i].m)
                       + dsd_pkg::OFF_W'(leap && (s1_ff[i].m > dsd_pkg::FEBRUARY))
                       + dsd_pkg::OFF_W'(s1_ff[i].d);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) s2_ff <= s2_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: finish the day numbers; combine the date checks.
   // ---------------------------------------------------------------------
   logic [dsd_pkg::DN_W-1:0] n_in [NDATE];
   logic [dsd_pkg::DN_W-1:0] n_ff [NDATE];
   logic                     ok3_in, ok3_ff;

   always_comb begin
      for (int i = 0; i < NDATE; i++) begin
         n_in[i] = s2_ff[i].base + dsd_pkg::DN_W'(s2_ff[i].off);
      end
      ok3_in = s2_ff[0].ok && s2_ff[1].ok && s2_ff[2].ok;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         n_ff   <= n_in;
         ok3_ff <= ok3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: pick the earliest and the latest day number.
   // ---------------------------------------------------------------------
   logic [dsd_pkg::DN_W-1:0] lo_in, hi_in, lo_ff, hi_ff;
   logic                     ok4_ff;

   always_comb begin
      lo_in = (n_ff[1] < n_ff[0]) ? n_ff[1] : n_ff[0];
      hi_in = (n_ff[1] > n_ff[0]) ? n_ff[1] : n_ff[0];
      if (n_ff[2] < lo_in) lo_in = n_ff[2];
      if (n_ff[2] > hi_in) hi_in = n_ff[2];
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         ok4_ff <= ok3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: span and output register; drop the span on an invalid word.
   // ---------------------------------------------------------------------
   logic [dsd_pkg::DN_W-1:0]   diff;
   logic [dsd_pkg::SPAN_W-1:0] span_in, span_ff;
   logic                       all_valid_ff;

   assign diff    = hi_ff - lo_ff;
   assign span_in = ok4_ff ? diff[dsd_pkg::SPAN_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (adv5) begin
         span_ff      <= span_in;
         all_valid_ff <= ok4_ff;
      end
   end

   assign rsp_all_valid = all_valid_ff;
   assign rsp_span_days = span_ff;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int          HALF_PERIOD  = 1;
   localparam int          RESET_CYCLES = 11;
   localparam int          IDLE_PCT     = 21;
   localparam int          RANDOM_WORDS = 1100;
   // Words of the random part sent with neither side idling.
   localparam int          CALM_FROM    = 400;
   localparam int          CALM_UNTIL   = 600;
   // Pipeline is five stages deep; give it plenty of slack at the end.
   localparam int          TAIL_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned LAST_YEAR    = 9999;

   localparam bit PREDICTED = 1'b0;
   localparam bit TYPED     = 1'b1;

   // Days before the first of each month in a common year.
   localparam int unsigned DAYS_BEFORE [12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };

   typedef struct packed {
      logic [dsd_pkg::DAY_W-1:0]  day;
      logic [dsd_pkg::MON_W-1:0]  month;
      logic [dsd_pkg::YEAR_W-1:0] year;
   } cal_date_type;

   typedef struct packed {
      cal_date_type first;
      cal_date_type second;
      cal_date_type third;
   } day_trio_type;

   typedef struct packed {
      logic                       ok;
      logic [dsd_pkg::SPAN_W-1:0] span;
   } span_note_type;

   typedef struct packed {
      day_trio_type  trio;
      bit            typed;
      span_note_type note;
   } plan_row_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_all_valid;
   logic [dsd_pkg::SPAN_W-1:0] rsp_span_days;

   // The word on the request port, plus what the table says about it.
   day_trio_type  cur_trio   = '0;
   bit            cur_typed  = PREDICTED;
   span_note_type cur_note   = '0;
   bit            calm_phase = 1'b0;

   span_note_type spans_due[$];
   int            mismatches  = 0;
   int unsigned   cycle_count = 0;

   always #(HALF_PERIOD) clock = ~clock;

   date_span_in_days_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_day    (cur_trio.first.day),
      .req_first_month  (cur_trio.first.month),
      .req_first_year   (cur_trio.first.year),
      .req_second_day   (cur_trio.second.day),
      .req_second_month (cur_trio.second.month),
      .req_second_year  (cur_trio.second.year),
      .req_third_day    (cur_trio.third.day),
      .req_third_month  (cur_trio.third.month),
      .req_third_year   (cur_trio.third.year),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_all_valid    (rsp_all_valid),
      .rsp_span_days    (rsp_span_days)
   );

   // ---------------------------------------------------------------
   // Calendar arithmetic for the expected span
   // ---------------------------------------------------------------

   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      case (m)
         2:             return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic bit date_is_real(input cal_date_type c);
      if (c.year < 1 || c.year > LAST_YEAR) return 1'b0;
      if (c.month < 1 || c.month > 12) return 1'b0;
      if (c.day < 1) return 1'b0;
      return c.day <= month_length(c.month, c.year);
   endfunction

   // Day 1 is 1 January of year 1; valid dates only.
   function automatic int unsigned day_count(input cal_date_type c);
      int unsigned p;
      int unsigned n;
      p = int'(c.year) - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      n += DAYS_BEFORE[int'(c.month) - 1];
      if (c.month > 2 && is_leap(c.year)) n += 1;
      return n + c.day;
   endfunction

   function automatic span_note_type reckon_span(input day_trio_type t);
      span_note_type r;
      int unsigned   n [3];
      int unsigned   lo;
      int unsigned   hi;
      r = '0;
      if (!(date_is_real(t.first) && date_is_real(t.second) && date_is_real(t.third)))
         return r;
      n[0] = day_count(t.first);
      n[1] = day_count(t.second);
      n[2] = day_count(t.third);
      lo = n[0];
      hi = n[0];
      for (int i = 1; i < 3; i++) begin
         if (n[i] < lo) lo = n[i];
         if (n[i] > hi) hi = n[i];
      end
      r.ok   = 1'b1;
      r.span = dsd_pkg::SPAN_W'(hi - lo);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------

   function automatic cal_date_type dmy(input int d, input int m, input int y);
      cal_date_type c;
      c.day   = dsd_pkg::DAY_W'(d);
      c.month = dsd_pkg::MON_W'(m);
      c.year  = dsd_pkg::YEAR_W'(y);
      return c;
   endfunction

   function automatic plan_row_type plan_row(input cal_date_type a, input cal_date_type b,
                                             input cal_date_type c, input bit typed,
                                             input logic ok, input int span);
      plan_row_type r;
      r.trio.first  = a;
      r.trio.second = b;
      r.trio.third  = c;
      r.typed       = typed;
      r.note.ok     = ok;
      r.note.span   = dsd_pkg::SPAN_W'(span);
      return r;
   endfunction

   // Mostly valid dates, weighted toward the ends of the year range,
   // century leap boundaries and the last day of a month.
   function automatic cal_date_type pick_date();
      cal_date_type c;
      int unsigned  roll;
      int unsigned  y;
      int unsigned  m;
      int unsigned  len;
      roll = $urandom_range(0, 99);
      if (roll < 7) begin
         // raw noise over the full field ranges
         c.day   = dsd_pkg::DAY_W'($urandom_range(0, 31));
         c.month = dsd_pkg::MON_W'($urandom_range(0, 15));
         c.year  = dsd_pkg::YEAR_W'($urandom_range(0, 16383));
         return c;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15)      y = $urandom_range(1, 60);
      else if (roll < 30) y = $urandom_range(LAST_YEAR - 59, LAST_YEAR);
      else if (roll < 45) y = 400 * $urandom_range(1, 24) + $urandom_range(0, 8) - 4;
      else                y = $urandom_range(1, LAST_YEAR);
      m   = $urandom_range(1, 12);
      len = month_length(m, y);
      roll = $urandom_range(0, 99);
      c.year  = dsd_pkg::YEAR_W'(y);
      c.month = dsd_pkg::MON_W'(m);
      if (roll < 25)      c.day = dsd_pkg::DAY_W'(len);
      else if (roll < 32) c.day = dsd_pkg::DAY_W'(1);
      else                c.day = dsd_pkg::DAY_W'($urandom_range(1, len));
      // break one field outside its legal range now and then
      if ($urandom_range(0, 99) < 5) begin
         case ($urandom_range(0, 3))
            0: c.day   = '0;
            1: c.day   = (len < 31) ? dsd_pkg::DAY_W'(len + 1) : dsd_pkg::DAY_W'(0);
            2: c.month = ($urandom_range(0, 1) != 0) ?
                         dsd_pkg::MON_W'($urandom_range(13, 15)) : '0;
            default: c.year = ($urandom_range(0, 1) != 0) ?
                              dsd_pkg::YEAR_W'($urandom_range(LAST_YEAR + 1, 16383)) : '0;
         endcase
      end
      return c;
   endfunction

   function automatic day_trio_type pick_trio();
      day_trio_type t;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      t.first  = pick_date();
      t.second = pick_date();
      t.third  = pick_date();
      if (roll < 5) begin
         // equal dates
         t.second = t.first;
         t.third  = t.first;
      end else if (roll < 20) begin
         // same year: short spans, leap day inside or outside
         t.second.year = t.first.year;
         t.third.year  = t.first.year;
      end
      return t;
   endfunction

   // Offer one word; return at the edge that accepts it.
   task automatic offer(input day_trio_type t, input bit typed, input span_note_type note);
      while (!calm_phase && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      cur_trio  <= t;
      cur_typed <= typed;
      cur_note  <= note;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // ---------------------------------------------------------------
   // Request side: directed table, then random words
   // ---------------------------------------------------------------

   initial begin : stimulus
      plan_row_type plan[$];

      // Extremes, the range checks on every field, the leap rule and
      // equal dates. Rows whose answer is obvious carry it here.
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 1), dmy(1, 1, 1), TYPED, 1'b1, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(31, 12, 9999), dmy(1, 1, 1),
                              TYPED, 1'b1, 3652058));
      plan.push_back(plan_row(dmy(31, 12, 9999), dmy(31, 12, 9999), dmy(31, 12, 9999),
                              TYPED, 1'b1, 0));
      plan.push_back(plan_row(dmy(1, 1, 0), dmy(1, 1, 1), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 10000), dmy(1, 1, 1),
                              TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 1), dmy(31, 15, 16383),
                              TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(5, 0, 2000), dmy(1, 1, 1), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(5, 13, 2000), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 1), dmy(5, 15, 2000), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(0, 6, 2000), dmy(1, 1, 1), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(31, 4, 2000), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(29, 2, 1900), dmy(1, 1, 1), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(29, 2, 2001), dmy(1, 1, 1), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 1), dmy(30, 2, 2000), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(1, 1, 1), dmy(1, 1, 1), dmy(31, 6, 2000), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(0, 0, 0), dmy(0, 0, 0), dmy(0, 0, 0), TYPED, 1'b0, 0));
      plan.push_back(plan_row(dmy(29, 2, 2000), dmy(1, 3, 2000), dmy(28, 2, 2000),
                              PREDICTED, 1'b0, 0));
      plan.push_back(plan_row(dmy(29, 2, 2004), dmy(31, 1, 1), dmy(31, 12, 1999),
                              PREDICTED, 1'b0, 0));
      plan.push_back(plan_row(dmy(28, 2, 1900), dmy(1, 3, 1900), dmy(31, 12, 1899),
                              PREDICTED, 1'b0, 0));
      plan.push_back(plan_row(dmy(31, 12, 1600), dmy(1, 1, 1601), dmy(29, 2, 1600),
                              PREDICTED, 1'b0, 0));
      plan.push_back(plan_row(dmy(16, 6, 5000), dmy(15, 6, 5000), dmy(15, 6, 5000),
                              PREDICTED, 1'b0, 0));
      plan.push_back(plan_row(dmy(30, 11, 9999), dmy(1, 1, 9999), dmy(31, 10, 2024),
                              PREDICTED, 1'b0, 0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         offer(plan[i].trio, plan[i].typed, plan[i].note);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm_phase = (i >= CALM_FROM) && (i < CALM_UNTIL);
         offer(pick_trio(), PREDICTED, '0);
      end
      calm_phase = 1'b0;
      req_valid <= 1'b0;

      // Let the last accept land in the store before draining it.
      @(posedge clock);
      while (spans_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // Response side: random back-pressure, drop it during the calm stretch
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      rsp_ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------
   // Scoreboard: both handshakes are sampled at the edge, before any
   // update of that edge takes effect.
   // ---------------------------------------------------------------

   always @(posedge clock) begin : watch
      span_note_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            spans_due.push_back(cur_typed ? cur_note : reckon_span(cur_trio));
         if (rsp_valid && rsp_ready) begin
            if (spans_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word all_valid %0b span %0d",
                                         rsp_all_valid, rsp_span_days));
            end else begin
               want = spans_due.pop_front();
               if (rsp_all_valid !== want.ok)
                  report_mismatch($sformatf("all_valid %0b, want %0b",
                                            rsp_all_valid, want.ok));
               if (rsp_span_days !== want.span)
                  report_mismatch($sformatf("span_days %0d, want %0d",
                                            rsp_span_days, want.span));
            end
         end
      end
   end

   // Hard stop for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

[files.f]
sv/dsd_pkg.sv
sv/date_span_in_days_core.sv
tb/tb_top.sv
